@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the checker module.
// ASSERT_SAME: implication in the same cycle, held off during reset.
// ASSERT_NEXT: implication into the next cycle, held off during reset.
// ASSERT_NEXT_ALWAYS: implication into the next cycle, checked in reset too.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`define ASSERT_NEXT_ALWAYS(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/sscc_pkg.sv @@
// ----------------------------------------------------------------------------
// Shell script character classifier package
// Style codes, lexer mode codes, shared types and character class helpers.
// ----------------------------------------------------------------------------
package sscc_pkg;

    // Style codes carried on the result stream.
    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_CONTROL  = 3'd1;
    localparam logic [2:0] ST_DEFINE   = 3'd2;
    localparam logic [2:0] ST_VARTYPE  = 3'd3;
    localparam logic [2:0] ST_CONST    = 3'd4;
    localparam logic [2:0] ST_COMMENT  = 3'd5;
    localparam logic [2:0] ST_NONASCII = 3'd6;

    // Lexer mode codes.
    localparam logic [3:0] M_NORMAL  = 4'd0;
    localparam logic [3:0] M_COMMENT = 4'd1;
    localparam logic [3:0] M_SQUOTE  = 4'd2;
    localparam logic [3:0] M_DQUOTE  = 4'd3;
    localparam logic [3:0] M_ZERO    = 4'd4;
    localparam logic [3:0] M_INT     = 4'd5;
    localparam logic [3:0] M_FRAC    = 4'd6;
    localparam logic [3:0] M_EXPSIGN = 4'd7;
    localparam logic [3:0] M_EXP     = 4'd8;
    localparam logic [3:0] M_HEX     = 4'd9;

    // One input request.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_first;
        logic       line_final;
        logic       range_restart;
    } t_item;

    // Lexer state carried from byte to byte.
    typedef struct packed {
        logic [3:0] lexer_mode;
        logic [7:0] previous_byte;
        logic [7:0] byte_before_previous;
        logic       escape_toggle;
    } t_lex_state;

    function automatic logic is_dig(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_xdig(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h61:8'h7a], [8'h41:8'h5a], 8'h5f};
    endfunction

endpackage

@@ hw/rtl/sscc_classify.sv @@
// ----------------------------------------------------------------------------
// Shell script character classifier: byte classification logic
// Combinational mode update and style decision for one byte.
// ----------------------------------------------------------------------------
module sscc_classify (
    input  sscc_pkg::t_item      i_item,
    input  sscc_pkg::t_lex_state i_state,
    output sscc_pkg::t_lex_state o_state,
    output logic [2:0]           o_style,
    output logic                 o_restyle
);

    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       esc;
    logic [3:0] mode;
    logic [3:0] nx_mode;
    logic       nx_esc;
    logic       again;
    logic       two_op;
    logic [7:0] quote_ch;

    // Line start and range restart adjust the state before the byte is seen.
    always_comb begin
        c0   = i_item.text_byte;
        c1   = i_item.line_first ? 8'h00 : i_state.previous_byte;
        c2   = i_item.line_first ? 8'h00 : i_state.byte_before_previous;
        esc  = i_item.line_first ? 1'b0 : i_state.escape_toggle;
        mode = i_state.lexer_mode;
        if (i_item.line_first && mode != sscc_pkg::M_SQUOTE
                && mode != sscc_pkg::M_DQUOTE) begin
            mode = sscc_pkg::M_NORMAL;
        end
        if (i_item.range_restart) begin
            mode = sscc_pkg::M_NORMAL;
        end
    end

    // Two-byte operators that restyle the previous byte.
    always_comb begin
        case (c0)
            8'h3d:   two_op = c1 inside {8'h3d, 8'h7c, 8'h26, 8'h21, 8'h2b, 8'h2d};
            8'h26:   two_op = (c1 == 8'h26);
            8'h7c:   two_op = (c1 == 8'h7c);
            default: two_op = 1'b0;
        endcase
    end

    // Mode dependent handling; bytes that fall out of a mode go to the
    // normal-mode rules below.
    always_comb begin
        nx_mode   = mode;
        nx_esc    = esc;
        o_style   = sscc_pkg::ST_NONE;
        o_restyle = 1'b0;
        again     = 1'b0;
        quote_ch  = (mode == sscc_pkg::M_SQUOTE) ? 8'h27 : 8'h22;
        case (mode)
            sscc_pkg::M_COMMENT: begin
                o_style = sscc_pkg::ST_COMMENT;
            end
            sscc_pkg::M_SQUOTE, sscc_pkg::M_DQUOTE: begin
                o_style = sscc_pkg::ST_CONST;
                if (c0 == quote_ch && (c1 != 8'h5c || esc)) begin
                    nx_mode = sscc_pkg::M_NORMAL;
                    nx_esc  = 1'b0;
                end else if (c1 == 8'h5c && c0 == 8'h5c) begin
                    nx_esc = ~esc;
                end else begin
                    nx_esc = 1'b0;
                end
            end
            sscc_pkg::M_ZERO, sscc_pkg::M_INT: begin
                o_style = sscc_pkg::ST_CONST;
                if (mode == sscc_pkg::M_ZERO && c0 == 8'h78 && !i_item.line_final) begin
                    nx_mode = sscc_pkg::M_HEX;
                end else if (c0 == 8'h2e) begin
                    nx_mode = sscc_pkg::M_FRAC;
                end else if (c0 == 8'h65 || c0 == 8'h45) begin
                    nx_mode = sscc_pkg::M_EXPSIGN;
                end else if (sscc_pkg::is_dig(c0)) begin
                    nx_mode = sscc_pkg::M_INT;
                end else begin
                    again = 1'b1;
                end
            end
            sscc_pkg::M_FRAC: begin
                o_style = sscc_pkg::ST_CONST;
                if (sscc_pkg::is_dig(c0)) begin
                    nx_mode = sscc_pkg::M_FRAC;
                end else if (c0 == 8'h65 || c0 == 8'h45) begin
                    nx_mode = sscc_pkg::M_EXPSIGN;
                end else begin
                    again = 1'b1;
                end
            end
            sscc_pkg::M_EXPSIGN, sscc_pkg::M_EXP: begin
                o_style = sscc_pkg::ST_CONST;
                if ((mode == sscc_pkg::M_EXPSIGN && (c0 == 8'h2b || c0 == 8'h2d))
                        || sscc_pkg::is_dig(c0)) begin
                    nx_mode = sscc_pkg::M_EXP;
                end else begin
                    again = 1'b1;
                end
            end
            sscc_pkg::M_HEX: begin
                o_style = sscc_pkg::ST_CONST;
                if (!sscc_pkg::is_xdig(c0)) begin
                    again = 1'b1;
                end
            end
            default: begin
                again = 1'b1;
            end
        endcase

        // Normal-mode rules.
        if (again) begin
            if (c0 == 8'h23 && c1 != 8'h24) begin
                nx_mode = sscc_pkg::M_COMMENT;
                o_style = sscc_pkg::ST_COMMENT;
            end else if (c0 == 8'h27 && (c1 != 8'h5c || c2 == 8'h5c)) begin
                nx_mode = sscc_pkg::M_SQUOTE;
                nx_esc  = 1'b0;
                o_style = sscc_pkg::ST_CONST;
            end else if (c0 == 8'h22 && (c1 != 8'h5c || c2 == 8'h5c)) begin
                nx_mode = sscc_pkg::M_DQUOTE;
                nx_esc  = 1'b0;
                o_style = sscc_pkg::ST_CONST;
            end else if (!sscc_pkg::is_ident(c1) && sscc_pkg::is_dig(c0)) begin
                nx_mode = (c0 == 8'h30) ? sscc_pkg::M_ZERO : sscc_pkg::M_INT;
                o_style = sscc_pkg::ST_CONST;
            end else begin
                nx_mode = sscc_pkg::M_NORMAL;
                if (two_op) begin
                    o_restyle = 1'b1;
                    o_style   = sscc_pkg::ST_CONTROL;
                end else if (c0 == 8'h24) begin
                    o_style = sscc_pkg::ST_DEFINE;
                end else if (c0 inside {8'h26, 8'h23, 8'h2e, 8'h2a, 8'h5b, 8'h5d}) begin
                    o_style = sscc_pkg::ST_VARTYPE;
                end else if (c0 inside {8'h3d, 8'h40, 8'h5e, 8'h7e, 8'h3a, 8'h25,
                                        8'h2b, 8'h2d, 8'h3c, 8'h3e, 8'h21, 8'h3f,
                                        8'h28, 8'h29, 8'h7b, 8'h7d, 8'h2c, 8'h3b,
                                        8'h2f, 8'h7c}) begin
                    o_style = sscc_pkg::ST_CONTROL;
                end else if (!(c0 inside {[8'd32:8'd126]})) begin
                    o_style = sscc_pkg::ST_NONASCII;
                end else begin
                    o_style = sscc_pkg::ST_NONE;
                end
            end
        end
    end

    // Next state, including the byte history shift.
    always_comb begin
        o_state.lexer_mode           = nx_mode;
        o_state.escape_toggle        = nx_esc;
        o_state.previous_byte        = c0;
        o_state.byte_before_previous = c1;
    end

endmodule

@@ hw/rtl/shell_script_char_classifier_top.sv @@
// ----------------------------------------------------------------------------
// Shell script character classifier
// Input register, classification logic and output register with stream
// handshakes on both sides.
// ----------------------------------------------------------------------------
// A request waits in the input register until the output register is free,
// then passes the classification logic into the output register while the
// lexer state register takes the new state. One byte per cycle while the
// sink takes results; the input register refills while a result waits.
// Reset clears the lexer state (normal mode, empty history, escape clear)
// and both valid flags; the block is ready as soon as reset is released.
module shell_script_char_classifier_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] text_byte
    input  logic       i_s_tlast,   // line_final
    input  logic [1:0] i_s_tuser,   // [0] line_first, [1] range_restart
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [2:0] style_code, [7:3] zero
    output logic       o_m_tuser    // restyle_previous
);

    sscc_pkg::t_item      r_in;
    sscc_pkg::t_item      n_in;
    logic                 r_in_valid;
    logic                 n_in_valid;
    sscc_pkg::t_lex_state r_state;
    sscc_pkg::t_lex_state n_state;
    sscc_pkg::t_lex_state cls_state;
    logic [2:0]           r_style;
    logic [2:0]           n_style;
    logic                 r_restyle;
    logic                 n_restyle;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [2:0]           cls_style;
    logic                 cls_restyle;
    logic                 out_free;
    logic                 advance;
    logic                 s_take;

    // Handshake control.
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign s_take     = i_s_tvalid && o_s_tready;

    sscc_classify u_classify (
        .i_item    (r_in),
        .i_state   (r_state),
        .o_state   (cls_state),
        .o_style   (cls_style),
        .o_restyle (cls_restyle)
    );

    // Next values for the input stage, state and output stage.
    always_comb begin
        n_in        = r_in;
        n_in_valid  = r_in_valid;
        n_state     = r_state;
        n_style     = r_style;
        n_restyle   = r_restyle;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_in_valid  = 1'b0;
            n_state     = cls_state;
            n_style     = cls_style;
            n_restyle   = cls_restyle;
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (s_take) begin
            n_in.text_byte     = i_s_tdata;
            n_in.line_first    = i_s_tuser[0];
            n_in.line_final    = i_s_tlast;
            n_in.range_restart = i_s_tuser[1];
            n_in_valid         = 1'b1;
        end
    end

    // Control state and lexer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_in      <= n_in;
        r_style   <= n_style;
        r_restyle <= n_restyle;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_style};
    assign o_m_tuser  = r_restyle;

endmodule

@@ hw/rtl/sscc_checker.sv @@
// ----------------------------------------------------------------------------
// Shell script character classifier checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sscc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic       i_s_tlast,
    input logic [1:0] i_s_tuser,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tuser
);

    logic unused_inputs;

    // Input side is not checked here.
    assign unused_inputs = i_s_tvalid ^ o_s_tready ^ (^i_s_tdata) ^ i_s_tlast ^ (^i_s_tuser);

    // No result is shown in the cycle after reset.
    `ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_m_tvalid)

    // A stalled result holds its value.
    `ASSERT_NEXT(a_stall_hold, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // A restyle flag only comes with a control style.
    `ASSERT_SAME(a_restyle_control, o_m_tvalid && o_m_tuser,
        o_m_tdata[2:0] == sscc_pkg::ST_CONTROL)

    // Style codes stay in range and the padding stays zero.
    `ASSERT_SAME(a_style_range, o_m_tvalid,
        o_m_tdata[2:0] != 3'd7 && o_m_tdata[7:3] == 5'd0)

endmodule

bind shell_script_char_classifier_top sscc_checker u_sscc_checker (.*);

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for the shell script character classifier
// Drives text bytes with line and range marks into the input stream. A
// scoreboard class keeps its own lexer state and predicts the style of every
// accepted request. Each result on the output stream is compared in order
// with those predictions. Both sides idle at random, and the sink holds off
// once for a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

    // Scoreboard: own lexer model plus the queue of predicted styles.
    class style_scoreboard;
        typedef struct packed {
            logic [2:0] style_code;
            logic       restyle_previous;
        } t_style;

        logic [3:0] lex_mode   = sscc_pkg::M_NORMAL;
        logic [7:0] prev_byte  = 8'd0;
        logic [7:0] prev2_byte = 8'd0;
        logic       esc_toggle = 1'b0;
        t_style     expected_styles[$];
        int         style_errors = 0;
        int         results_seen = 0;

        function logic char_in(input logic [7:0] c, input string set);
            for (int i = 0; i < set.len(); i++) begin
                if (set[i] == c) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function logic is_digit(input logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function logic is_hex_digit(input logic [7:0] c);
            return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        function logic is_word_char(input logic [7:0] c);
            return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
                || c == "_";
        endfunction

        // Style of a byte seen in normal mode; also picks the next mode.
        function logic [2:0] normal_style(input logic [7:0] c2, input logic [7:0] c1,
                                          input logic [7:0] c0, output logic restyle);
            restyle = 1'b0;
            if (c0 == "#" && c1 != "$") begin
                lex_mode = sscc_pkg::M_COMMENT;
                return sscc_pkg::ST_COMMENT;
            end
            if (c0 == "'" && (c1 != "\\" || c2 == "\\")) begin
                lex_mode   = sscc_pkg::M_SQUOTE;
                esc_toggle = 1'b0;
                return sscc_pkg::ST_CONST;
            end
            if (c0 == "\"" && (c1 != "\\" || c2 == "\\")) begin
                lex_mode   = sscc_pkg::M_DQUOTE;
                esc_toggle = 1'b0;
                return sscc_pkg::ST_CONST;
            end
            if (!is_word_char(c1) && is_digit(c0)) begin
                lex_mode = (c0 == "0") ? sscc_pkg::M_ZERO : sscc_pkg::M_INT;
                return sscc_pkg::ST_CONST;
            end
            lex_mode = sscc_pkg::M_NORMAL;
            // Two-byte operators turn the previous byte into control as well.
            if ((c0 == "=" && char_in(c1, "=|&!+-")) || (c0 == "&" && c1 == "&")
                || (c0 == "|" && c1 == "|")) begin
                restyle = 1'b1;
                return sscc_pkg::ST_CONTROL;
            end
            if (c0 == "$") return sscc_pkg::ST_DEFINE;
            if (char_in(c0, "&#.*[]")) return sscc_pkg::ST_VARTYPE;
            if (char_in(c0, "=@^~:%+-<>!?(){},;/|")) return sscc_pkg::ST_CONTROL;
            if (c0 < 8'd32 || c0 > 8'd126) return sscc_pkg::ST_NONASCII;
            return sscc_pkg::ST_NONE;
        endfunction

        // Inside a quote: find the closing quote and track backslash pairs.
        function void quote_update(input logic [7:0] q, input logic [7:0] c1,
                                   input logic [7:0] c0);
            if (c0 == q && (c1 != "\\" || esc_toggle)) begin
                lex_mode   = sscc_pkg::M_NORMAL;
                esc_toggle = 1'b0;
            end else if (c1 == "\\" && c0 == "\\") begin
                esc_toggle = ~esc_toggle;
            end else begin
                esc_toggle = 1'b0;
            end
        endfunction

        function t_style classify_byte(input sscc_pkg::t_item it);
            logic [7:0] c0;
            logic [7:0] c1;
            logic [7:0] c2;
            logic       again;
            logic       restyle;
            t_style     res;
            if (it.line_first) begin
                prev_byte  = 8'd0;
                prev2_byte = 8'd0;
                esc_toggle = 1'b0;
                if (lex_mode != sscc_pkg::M_SQUOTE && lex_mode != sscc_pkg::M_DQUOTE) begin
                    lex_mode = sscc_pkg::M_NORMAL;
                end
            end
            if (it.range_restart) lex_mode = sscc_pkg::M_NORMAL;
            c0      = it.text_byte;
            c1      = prev_byte;
            c2      = prev2_byte;
            again   = 1'b0;
            restyle = 1'b0;
            res.style_code       = sscc_pkg::ST_NONE;
            res.restyle_previous = 1'b0;
            case (lex_mode)
                sscc_pkg::M_COMMENT: begin
                    res.style_code = sscc_pkg::ST_COMMENT;
                end
                sscc_pkg::M_SQUOTE: begin
                    quote_update("'", c1, c0);
                    res.style_code = sscc_pkg::ST_CONST;
                end
                sscc_pkg::M_DQUOTE: begin
                    quote_update("\"", c1, c0);
                    res.style_code = sscc_pkg::ST_CONST;
                end
                sscc_pkg::M_ZERO, sscc_pkg::M_INT: begin
                    // Hex only starts when the 'x' is not the last byte of its line.
                    if (lex_mode == sscc_pkg::M_ZERO && c0 == "x" && !it.line_final) begin
                        lex_mode = sscc_pkg::M_HEX;
                    end else if (c0 == ".") begin
                        lex_mode = sscc_pkg::M_FRAC;
                    end else if (c0 == "e" || c0 == "E") begin
                        lex_mode = sscc_pkg::M_EXPSIGN;
                    end else if (is_digit(c0)) begin
                        lex_mode = sscc_pkg::M_INT;
                    end else begin
                        again = 1'b1;
                    end
                    res.style_code = sscc_pkg::ST_CONST;
                end
                sscc_pkg::M_FRAC: begin
                    if (c0 == "e" || c0 == "E") begin
                        lex_mode = sscc_pkg::M_EXPSIGN;
                    end else if (!is_digit(c0)) begin
                        again = 1'b1;
                    end
                    res.style_code = sscc_pkg::ST_CONST;
                end
                sscc_pkg::M_EXPSIGN, sscc_pkg::M_EXP: begin
                    if ((lex_mode == sscc_pkg::M_EXPSIGN && (c0 == "+" || c0 == "-"))
                        || is_digit(c0)) begin
                        lex_mode = sscc_pkg::M_EXP;
                    end else begin
                        again = 1'b1;
                    end
                    res.style_code = sscc_pkg::ST_CONST;
                end
                sscc_pkg::M_HEX: begin
                    if (!is_hex_digit(c0)) again = 1'b1;
                    res.style_code = sscc_pkg::ST_CONST;
                end
                default: begin
                    again = 1'b1;
                end
            endcase
            // The byte that ends a number is looked at again in normal mode.
            if (again) begin
                res.style_code       = normal_style(c2, c1, c0, restyle);
                res.restyle_previous = restyle;
            end
            prev2_byte = prev_byte;
            prev_byte  = c0;
            return res;
        endfunction

        function void note_request(input sscc_pkg::t_item it);
            expected_styles.push_back(classify_byte(it));
        endfunction

        task report_mismatch(input string what);
            $display("ERROR: %s", what);
            style_errors++;
        endtask

        task check_result(input logic [2:0] style, input logic restyle);
            t_style want;
            results_seen++;
            if (expected_styles.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing predicted",
                                          results_seen));
                return;
            end
            want = expected_styles.pop_front();
            if (style !== want.style_code) begin
                report_mismatch($sformatf("result %0d: style_code %0d, predicted %0d",
                                          results_seen, style, want.style_code));
            end
            if (restyle !== want.restyle_previous) begin
                report_mismatch($sformatf("result %0d: restyle_previous %0b, predicted %0b",
                                          results_seen, restyle, want.restyle_previous));
            end
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'd0;
    logic       s_tlast  = 1'b0;
    logic [1:0] s_tuser  = 2'd0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tuser;

    style_scoreboard sb;
    int          send_idle    = 0;
    int          recv_idle    = 0;
    int          bytes_sent   = 0;
    logic        hold_trigger = 1'b0;
    logic        hold_used    = 1'b0;
    int          hold_left    = 0;
    logic [7:0]  line_buf[$];

    shell_script_char_classifier_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [7:0] text_byte
        .i_s_tlast  (s_tlast),   // line_final
        .i_s_tuser  (s_tuser),   // [0] line_first, [1] range_restart
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // [2:0] style_code, [7:3] zero
        .o_m_tuser  (m_tuser)    // restyle_previous
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit far beyond the slowest correct run.
    initial begin
        #(8 * 400000);
        $display("shell_script_char_classifier_top: mismatch");
        $finish;
    end

    // Sink side: check accepted results, then pick the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            sb.check_result(m_tdata[2:0], m_tuser);
        end
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_trigger && !hold_used) begin
            m_tready  <= 1'b0;
            hold_used <= 1'b1;
            hold_left <= 200;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Offer one request and wait until it is accepted.
    task automatic send_request(input logic [7:0] b, input logic lf, input logic ll,
                                input logic rr);
        sscc_pkg::t_item it;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= ll;
        s_tuser  <= {rr, lf};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        it.text_byte     = b;
        it.line_first    = lf;
        it.line_final    = ll;
        it.range_restart = rr;
        sb.note_request(it);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_request(s[i], i == 0, i == s.len() - 1, 1'b0);
        end
    endtask

    // Stop offering and wait until every predicted style has come out.
    task automatic wait_for_styles();
        s_tvalid <= 1'b0;
        while (sb.expected_styles.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_char(input string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    // Build one shell-like line from random tokens.
    task automatic build_line();
        int    tokens;
        int    n;
        int    k;
        string letters;
        string word_chars;
        string ops;
        letters    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
        word_chars = "abcxyzeEABX_0123456789";
        ops        = "==&&||!=+=-=|=&=";
        line_buf.delete();
        tokens = $urandom_range(1, 7);
        for (int t = 0; t < tokens; t++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    line_buf.push_back(pick_char(letters));
                    n = $urandom_range(0, 5);
                    repeat (n) line_buf.push_back(pick_char(word_chars));
                end
                2, 3: begin
                    if ($urandom_range(99) < 25) begin
                        line_buf.push_back("0");
                        line_buf.push_back("x");
                        n = $urandom_range(0, 4);
                        repeat (n) line_buf.push_back(pick_char("0123456789abcdefABCDEFg"));
                    end else begin
                        n = $urandom_range(1, 3);
                        repeat (n) line_buf.push_back(pick_char("0123456789"));
                        if ($urandom_range(99) < 40) begin
                            line_buf.push_back(".");
                            n = $urandom_range(0, 2);
                            repeat (n) line_buf.push_back(pick_char("0123456789"));
                        end
                        if ($urandom_range(99) < 30) begin
                            line_buf.push_back(pick_char("eE"));
                            if ($urandom_range(1)) line_buf.push_back(pick_char("+-"));
                            n = $urandom_range(0, 2);
                            repeat (n) line_buf.push_back(pick_char("0123456789"));
                        end
                    end
                end
                4: begin
                    line_buf.push_back("'");
                    n = $urandom_range(0, 5);
                    repeat (n) line_buf.push_back(pick_char("ab \\\\'\"$#"));
                    if ($urandom_range(99) < 90) line_buf.push_back("'");
                end
                5: begin
                    line_buf.push_back("\"");
                    n = $urandom_range(0, 5);
                    repeat (n) line_buf.push_back(pick_char("ab \\\\\"'$#"));
                    if ($urandom_range(99) < 90) line_buf.push_back("\"");
                end
                6: begin
                    k = $urandom_range(0, 7);
                    line_buf.push_back(ops[2 * k]);
                    line_buf.push_back(ops[2 * k + 1]);
                end
                7: begin
                    line_buf.push_back("$");
                    line_buf.push_back(pick_char("#?@abcXY_1"));
                end
                8: begin
                    // A comment takes the rest of the line.
                    line_buf.push_back("#");
                    n = $urandom_range(0, 6);
                    repeat (n) line_buf.push_back(8'($urandom_range(32, 126)));
                    t = tokens;
                end
                default: begin
                    line_buf.push_back(pick_char("=@^~:%+-<>!?(){},;/|&.*[]\t"));
                end
            endcase
            if ($urandom_range(99) < 70) line_buf.push_back(" ");
        end
    endtask

    // Mostly well-formed lines with marks; some lines of raw bytes and flags.
    task automatic run_phase(input int s_idle, input int r_idle, input int count,
                             input logic with_hold);
        int start;
        int n;
        send_idle = s_idle;
        recv_idle = r_idle;
        start     = bytes_sent;
        while (bytes_sent - start < count) begin
            if ($urandom_range(99) < 15) begin
                n = $urandom_range(1, 12);
                repeat (n) begin
                    send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end else begin
                build_line();
                foreach (line_buf[i]) begin
                    send_request(line_buf[i], i == 0, i == line_buf.size() - 1,
                                 $urandom_range(99) < 3);
                end
            end
            if (with_hold && bytes_sent - start > 150) hold_trigger = 1'b1;
        end
    endtask

    // Main sequence: reset, directed bytes, then three random phases.
    initial begin
        int wait_cycles;
        sb = new;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 32;
        recv_idle = 60;
        // Byte zero, the top byte and a non-ASCII byte.
        send_request(8'h00, 1'b1, 1'b0, 1'b0);
        send_request(8'hFF, 1'b0, 1'b0, 1'b0);
        send_request(8'h80, 1'b0, 1'b1, 1'b0);
        // Hash after dollar is vartype; a later hash opens a comment.
        send_text("$#a#b");
        // Range restart inside a comment.
        send_request("c", 1'b0, 1'b1, 1'b1);
        // Escaped quote inside a single quote.
        send_text("'\\'x'");
        // Hex number ended by a dot, then an integer with a signed exponent.
        send_text("0xF.1e-2");
        // An 'x' after a leading zero at the end of the line is not hex.
        send_text("0x");
        send_text("a==b&&");
        // A backslash pair lets the closing double quote through.
        send_text("\"\\\\\"");
        wait_for_styles();

        run_phase(32, 60, 430, 1'b1);
        wait_for_styles();
        run_phase(60, 32, 430, 1'b0);
        wait_for_styles();
        run_phase(0, 0, 430, 1'b0);

        s_tvalid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 2000 && sb.expected_styles.size() != 0;
             wait_cycles++) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (sb.expected_styles.size() != 0) begin
            sb.report_mismatch($sformatf("%0d predicted results never arrived",
                                         sb.expected_styles.size()));
        end
        if (sb.style_errors == 0) begin
            $display("shell_script_char_classifier_top: match");
        end else begin
            $display("shell_script_char_classifier_top: mismatch");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/sscc_pkg.sv
hw/rtl/sscc_classify.sv
hw/rtl/shell_script_char_classifier_top.sv
hw/rtl/sscc_checker.sv
bench/testbench.sv
